@@ rtl/lower_triangle_correlation_accumulator_defines.svh @@
// assertion macros used by the correlation accumulator top level
`ifndef LOWER_TRIANGLE_CORRELATION_ACCUMULATOR_DEFINES_SVH
`define LOWER_TRIANGLE_CORRELATION_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LTCA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ltca check failed");

// next-cycle implication, checked outside reset
`define LTCA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ltca check failed");

`endif

@@ rtl/ltca_pkg.sv @@
// types and constants of the correlation accumulator
package ltca_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 48;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS;
  localparam int CPROD_BITS  = PROD_BITS + 1;

  localparam logic [1:0] REQ_SAMPLE = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  typedef logic        [1:0]             req_t;
  typedef logic        [3:0]             idx_t;
  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [CPROD_BITS-1:0]  cprod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  // one multiply-accumulate issued to the mac pipeline
  typedef struct packed {
    logic    vld;
    sample_t a_re;
    sample_t a_im;
    sample_t b_re;
    sample_t b_im;
    acc_t    acc_re;
    acc_t    acc_im;
  } mac_op_t;

  // write-back of one accumulator entry
  typedef struct packed {
    logic en;
    acc_t re;
    acc_t im;
  } acc_wr_t;

endpackage

@@ rtl/ltca_if.sv @@
// valid/ready channels of the correlation accumulator
interface ltca_in_if import ltca_pkg::*; ();
  logic    valid;
  logic    ready;
  req_t    req_type;
  idx_t    row;
  idx_t    column;
  sample_t sample_re;
  sample_t sample_im;

  modport source (output valid, req_type, row, column, sample_re, sample_im, input ready);
  modport sink   (input valid, req_type, row, column, sample_re, sample_im, output ready);
endinterface

interface ltca_out_if import ltca_pkg::*; ();
  logic valid;
  logic ready;
  acc_t acc_re;
  acc_t acc_im;
  logic entry_valid;

  modport source (output valid, acc_re, acc_im, entry_valid, input ready);
  modport sink   (input valid, acc_re, acc_im, entry_valid, output ready);
endinterface

@@ rtl/ltca_cmac.sv @@
// pipelined complex multiply with saturating accumulate
module ltca_cmac import ltca_pkg::*; #(
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mac_op_t           op,
  input  logic [ADDR_W-1:0] op_addr,
  output acc_wr_t           wr,
  output logic [ADDR_W-1:0] wr_addr,
  output logic              busy
);

  localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  function automatic acc_t sat_add(acc_t a, cprod_t p);
    logic signed [ACC_BITS:0] s;
    s = (ACC_BITS+1)'(a) + (ACC_BITS+1)'(p);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_BITS-1:0];
  endfunction

  // stage 1: four partial products
  logic              s1_vld_r;
  logic [ADDR_W-1:0] s1_addr_r;
  prod_t             p_rr_r, p_ii_r, p_ri_r, p_ir_r;
  acc_t              s1_acc_re_r, s1_acc_im_r;

  // stage 2: complex product
  logic              s2_vld_r;
  logic [ADDR_W-1:0] s2_addr_r;
  cprod_t            pre_r, pim_r;
  acc_t              s2_acc_re_r, s2_acc_im_r;

  acc_wr_t           wr_r;
  logic [ADDR_W-1:0] wr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      wr_r.en  <= 1'b0;
    end else begin
      s1_vld_r <= op.vld;
      s2_vld_r <= s1_vld_r;
      wr_r.en  <= s2_vld_r;
    end
    s1_addr_r   <= op_addr;
    p_rr_r      <= PROD_BITS'(op.a_re) * PROD_BITS'(op.b_re);
    p_ii_r      <= PROD_BITS'(op.a_im) * PROD_BITS'(op.b_im);
    p_ri_r      <= PROD_BITS'(op.a_re) * PROD_BITS'(op.b_im);
    p_ir_r      <= PROD_BITS'(op.a_im) * PROD_BITS'(op.b_re);
    s1_acc_re_r <= op.acc_re;
    s1_acc_im_r <= op.acc_im;

    s2_addr_r   <= s1_addr_r;
    pre_r       <= CPROD_BITS'(p_rr_r) - CPROD_BITS'(p_ii_r);
    pim_r       <= CPROD_BITS'(p_ri_r) + CPROD_BITS'(p_ir_r);
    s2_acc_re_r <= s1_acc_re_r;
    s2_acc_im_r <= s1_acc_im_r;

    wr_addr_r   <= s2_addr_r;
    wr_r.re     <= sat_add(s2_acc_re_r, pre_r);
    wr_r.im     <= sat_add(s2_acc_im_r, pim_r);
  end

  assign wr      = wr_r;
  assign wr_addr = wr_addr_r;
  assign busy    = s1_vld_r | s2_vld_r | wr_r.en;

endmodule

@@ rtl/lower_triangle_correlation_accumulator.sv @@
// top level: request sequencer, sample and accumulator memories, result register
//
//   channel | dir | payload                                     | handshake
//   in_ch   | in  | req_type, row, column, sample_re, sample_im | valid/ready
//   out_ch  | out | acc_re, acc_im, entry_valid                 | valid/ready
//
// a sample for element x makes x + 1 read-modify-write passes over the one accumulator
// memory port, then the mac pipeline drains before the next request is taken
// a read waits until the result register is free, a clear empties all entries on acceptance
// reset (synchronous, rst_n low) zeroes all accumulators at once through per-entry valid bits
// a full result register holds back a read at its memory access; no new request is taken meanwhile
module lower_triangle_correlation_accumulator import ltca_pkg::*; #(
  parameter int NUM_ELEMENTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  ltca_in_if.sink   in_ch,
  ltca_out_if.source out_ch
);

  `include "lower_triangle_correlation_accumulator_defines.svh"

  localparam int TRI_SIZE = NUM_ELEMENTS * (NUM_ELEMENTS + 1) / 2;
  localparam int TRI_AW   = $clog2(TRI_SIZE);
  localparam int ELEM_AW  = $clog2(NUM_ELEMENTS);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_RD_WAIT,
    ST_RD_DATA
  } state_t;

  state_t              state_r;
  logic [ELEM_AW-1:0]  x_r, y_r;
  logic [TRI_AW-1:0]   base_r;
  logic [TRI_AW-1:0]   rd_idx_r;
  logic                rd_entry_ok_r;
  sample_t             a_re_r, a_im_r;

  logic [2*SAMPLE_BITS-1:0] smp_mem [NUM_ELEMENTS];
  logic [2*SAMPLE_BITS-1:0] smp_q_r;
  logic [2*ACC_BITS-1:0]    acc_mem [TRI_SIZE];
  logic [2*ACC_BITS-1:0]    acc_q_r;
  logic [TRI_SIZE-1:0]      vld_r;
  logic                     acc_ok_r;
  logic                     rd_vld_r;
  logic [TRI_AW-1:0]        rd_addr_r;

  logic                out_vld_r;
  acc_t                out_re_r, out_im_r;
  logic                out_ok_r;

  logic                acc_rd_en;
  logic [TRI_AW-1:0]   acc_rd_addr;
  logic                in_acc;
  logic                row_ok;
  logic [7:0]          row_w, base_full, idx_full;

  mac_op_t             mac_op;
  acc_wr_t             mac_wr;
  logic [TRI_AW-1:0]   mac_wr_addr;
  logic                mac_busy;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid & in_ch.ready;
  assign row_ok      = 32'(in_ch.row) < NUM_ELEMENTS;

  // triangle base x*(x+1)/2 fits eight bits for rows below sixteen
  always_comb begin
    row_w     = {4'd0, in_ch.row};
    base_full = 8'((row_w * (row_w + 8'd1)) >> 1);
    idx_full  = base_full + {4'd0, in_ch.column};
  end

  assign acc_rd_en   = (state_r == ST_RUN) ||
                       (state_r == ST_RD_WAIT && (!out_vld_r || out_ch.ready));
  assign acc_rd_addr = (state_r == ST_RUN) ? base_r + TRI_AW'(y_r) : rd_idx_r;

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= (state_r == ST_RUN);
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            case (in_ch.req_type)
              REQ_SAMPLE: if (row_ok) state_r <= ST_RUN;
              REQ_READ:   state_r <= ST_RD_WAIT;
              default:    state_r <= ST_IDLE;
            endcase
          end
        end
        ST_RUN: begin
          if (y_r == x_r) state_r <= ST_DRAIN;
        end
        ST_DRAIN: begin
          if (!rd_vld_r && !mac_busy) state_r <= ST_IDLE;
        end
        ST_RD_WAIT: begin
          if (acc_rd_en) state_r <= ST_RD_DATA;
        end
        ST_RD_DATA: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end

    if (in_acc) begin
      x_r           <= in_ch.row[ELEM_AW-1:0];
      a_re_r        <= in_ch.sample_re;
      a_im_r        <= in_ch.sample_im;
      base_r        <= TRI_AW'(base_full);
      rd_entry_ok_r <= row_ok && (in_ch.column <= in_ch.row);
      rd_idx_r      <= (row_ok && (in_ch.column <= in_ch.row)) ? TRI_AW'(idx_full) : '0;
    end
    if (in_acc) begin
      y_r <= '0;
    end else if (state_r == ST_RUN) begin
      y_r <= y_r + ELEM_AW'(1);
    end
  end

  // sample memory: written when a sample is accepted, read one element per pass
  always_ff @(posedge clk) begin
    if (in_acc && in_ch.req_type == REQ_SAMPLE && row_ok) begin
      smp_mem[in_ch.row[ELEM_AW-1:0]] <= {in_ch.sample_re, in_ch.sample_im};
    end
    smp_q_r <= smp_mem[y_r];
  end

  // accumulator memory with per-entry valid bits standing in for zero
  always_ff @(posedge clk) begin
    if (mac_wr.en) begin
      acc_mem[mac_wr_addr] <= {mac_wr.re, mac_wr.im};
    end
    if (acc_rd_en) begin
      acc_q_r   <= acc_mem[acc_rd_addr];
      acc_ok_r  <= vld_r[acc_rd_addr];
      rd_addr_r <= acc_rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (in_acc && in_ch.req_type == REQ_CLEAR) begin
      vld_r <= '0;
    end else if (mac_wr.en) begin
      vld_r[mac_wr_addr] <= 1'b1;
    end
  end

  always_comb begin
    mac_op.vld    = rd_vld_r;
    mac_op.a_re   = a_re_r;
    mac_op.a_im   = a_im_r;
    mac_op.b_re   = smp_q_r[2*SAMPLE_BITS-1:SAMPLE_BITS];
    mac_op.b_im   = smp_q_r[SAMPLE_BITS-1:0];
    mac_op.acc_re = acc_ok_r ? acc_q_r[2*ACC_BITS-1:ACC_BITS] : '0;
    mac_op.acc_im = acc_ok_r ? acc_q_r[ACC_BITS-1:0] : '0;
  end

  ltca_cmac #(
    .ADDR_W (TRI_AW)
  ) u_cmac (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (mac_op),
    .op_addr (rd_addr_r),
    .wr      (mac_wr),
    .wr_addr (mac_wr_addr),
    .busy    (mac_busy)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (state_r == ST_RD_DATA) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
    if (state_r == ST_RD_DATA) begin
      out_re_r <= (acc_ok_r && rd_entry_ok_r) ? acc_q_r[2*ACC_BITS-1:ACC_BITS] : '0;
      out_im_r <= (acc_ok_r && rd_entry_ok_r) ? acc_q_r[ACC_BITS-1:0] : '0;
      out_ok_r <= rd_entry_ok_r;
    end
  end

  assign out_ch.valid       = out_vld_r;
  assign out_ch.acc_re      = out_re_r;
  assign out_ch.acc_im      = out_im_r;
  assign out_ch.entry_valid = out_ok_r;

  `LTCA_ASSERT_NOW(a_idle_means_drained, clk, rst_n, in_ch.ready, !mac_busy && !rd_vld_r)
  `LTCA_ASSERT_NOW(a_wb_only_in_sample, clk, rst_n, mac_wr.en,
                   state_r == ST_RUN || state_r == ST_DRAIN)
  `LTCA_ASSERT_NOW(a_result_slot_free, clk, rst_n, state_r == ST_RD_DATA, !out_vld_r)
  `LTCA_ASSERT_NEXT(a_clear_empties, clk, rst_n, in_acc && in_ch.req_type == REQ_CLEAR,
                    vld_r == '0)

endmodule

@@ test/tb_top.sv @@
// self-checking testbench for the lower-triangle correlation accumulator
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import ltca_pkg::*;

  localparam int     NUM_ELEM       = 16;
  localparam int     TRI_ENTRIES    = NUM_ELEM * (NUM_ELEM + 1) / 2;
  localparam longint ACC_HI         = (longint'(1) <<< (ACC_BITS - 1)) - 1;
  localparam longint ACC_LO         = -ACC_HI - 1;
  localparam int     HOLD_LEN       = 200;
  localparam int     WATCHDOG_LIMIT = 4000;
  localparam int     DRAIN_CYCLES   = 40;
  localparam int     MAX_GAP        = 60;
  localparam int     BIG_SAMPLES    = 40;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    acc_t re;
    acc_t im;
    logic valid;
  } entry_read_t;

  logic clk;
  logic rst_n;

  ltca_in_if  in_if ();
  ltca_out_if out_if ();

  lower_triangle_correlation_accumulator #(.NUM_ELEMENTS(NUM_ELEM)) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // predictor state
  sample_t     step_re [NUM_ELEM];
  sample_t     step_im [NUM_ELEM];
  logic [NUM_ELEM-1:0] step_written;
  acc_t        tri_re [TRI_ENTRIES];
  acc_t        tri_im [TRI_ENTRIES];
  entry_read_t pending_reads [$];

  int mismatch_count;
  int in_idle_pct;
  int out_stall_pct;
  int hold_req;
  int hold_done;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic acc_t sat_add(acc_t a, longint p);
    longint s;
    s = longint'(a) + p;
    if (s > ACC_HI) return acc_t'(ACC_HI);
    if (s < ACC_LO) return acc_t'(ACC_LO);
    return acc_t'(s);
  endfunction

  // apply one accepted word to the predicted matrix
  function automatic void update_correlation(req_t req, idx_t r, idx_t c,
                                             sample_t sre, sample_t sim);
    int base;
    longint pre;
    longint pim;
    entry_read_t rd;
    case (req)
      REQ_SAMPLE: begin
        step_re[r] = sre;
        step_im[r] = sim;
        step_written[r] = 1'b1;
        base = int'(r) * (int'(r) + 1) / 2;
        for (int y = 0; y <= int'(r); y++) begin
          pre = longint'(sre) * longint'(step_re[y]) - longint'(sim) * longint'(step_im[y]);
          pim = longint'(sre) * longint'(step_im[y]) + longint'(sim) * longint'(step_re[y]);
          tri_re[base + y] = sat_add(tri_re[base + y], pre);
          tri_im[base + y] = sat_add(tri_im[base + y], pim);
        end
      end
      REQ_READ: begin
        if (c <= r) begin
          base = int'(r) * (int'(r) + 1) / 2 + int'(c);
          rd.re = tri_re[base];
          rd.im = tri_im[base];
          rd.valid = 1'b1;
        end else begin
          rd.re = '0;
          rd.im = '0;
          rd.valid = 1'b0;
        end
        pending_reads.push_back(rd);
      end
      REQ_CLEAR: begin
        for (int i = 0; i < TRI_ENTRIES; i++) begin
          tri_re[i] = '0;
          tri_im[i] = '0;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic sample_t corner_value(int k);
    case (k)
      0: return sample_t'(16'h8000);
      1: return sample_t'(16'h7fff);
      2: return sample_t'(16'h0000);
      default: return sample_t'(16'hffff);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    int k;
    k = $urandom_range(7);
    if (k < 4) return corner_value(k);
    return sample_t'($urandom);
  endfunction

  // offer one word, optionally after an idle gap, and wait for it to be taken
  task automatic send_req(req_t req, idx_t r, idx_t c, sample_t sre, sample_t sim);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid     <= 1'b1;
    in_if.req_type  <= req;
    in_if.row       <= r;
    in_if.column    <= c;
    in_if.sample_re <= sre;
    in_if.sample_im <= sim;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    update_correlation(req, r, c, sre, sim);
  endtask

  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (pending_reads.size() != 0);
  endtask

  // fill one whole step with every corner combination, read back selected entries, then mix in other requests
  task automatic test_directed();
    in_idle_pct = 0;
    out_stall_pct = 0;
    for (int x = 0; x < NUM_ELEM; x++)
      send_req(REQ_SAMPLE, idx_t'(x), idx_t'(x), corner_value(x % 4), corner_value(x / 4));
    send_req(REQ_READ, 4'd0, 4'd0, '0, '0);
    send_req(REQ_READ, 4'd15, 4'd15, '0, '0);
    send_req(REQ_READ, 4'd15, 4'd0, '0, '0);
    send_req(REQ_READ, 4'd7, 4'd3, '0, '0);
    send_req(REQ_READ, 4'd3, 4'd7, '0, '0);
    send_req(REQ_READ, 4'd0, 4'd15, '0, '0);
    // element out of order reuses what is stored for the lower elements
    send_req(REQ_SAMPLE, 4'd5, 4'd9, corner_value(1), corner_value(0));
    send_req(REQ_READ, 4'd5, 4'd2, '0, '0);
    send_req(REQ_CLEAR, 4'd15, 4'd15, corner_value(3), corner_value(3));
    send_req(REQ_UNUSED, 4'd15, 4'd15, corner_value(0), corner_value(1));
    send_req(REQ_READ, 4'd15, 4'd0, '0, '0);
    send_req(REQ_SAMPLE, 4'd3, 4'd0, corner_value(0), corner_value(1));
    send_req(REQ_READ, 4'd3, 4'd3, '0, '0);
    wait_results_drained();
  endtask

  // pile the largest products into row one, reading back along the way
  task automatic test_large_products();
    in_idle_pct = 0;
    out_stall_pct = 0;
    send_req(REQ_CLEAR, 4'd0, 4'd0, '0, '0);
    send_req(REQ_SAMPLE, 4'd0, 4'd0, corner_value(1), corner_value(0));
    for (int i = 0; i < BIG_SAMPLES; i++) begin
      send_req(REQ_SAMPLE, 4'd1, 4'd0, corner_value(0), corner_value(0));
      if (i == BIG_SAMPLES - 6) begin
        send_req(REQ_READ, 4'd1, 4'd0, '0, '0);
        send_req(REQ_READ, 4'd1, 4'd1, '0, '0);
      end
    end
    send_req(REQ_READ, 4'd1, 4'd0, '0, '0);
    send_req(REQ_READ, 4'd1, 4'd1, '0, '0);
    send_req(REQ_READ, 4'd0, 4'd0, '0, '0);
    send_req(REQ_CLEAR, 4'd0, 4'd0, '0, '0);
    wait_results_drained();
  endtask

  // receiver holds off while reads keep coming, so the input backs up
  task automatic test_backpressure();
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req++;
    for (int i = 0; i < 24; i++) begin
      if (i % 3 == 0)
        send_req(REQ_SAMPLE, idx_t'(i / 2), idx_t'($urandom), rand_sample(), rand_sample());
      send_req(REQ_READ, idx_t'(i / 2), idx_t'(i / 4), '0, '0);
    end
    wait_results_drained();
  endtask

  task automatic test_drain_pause();
    in_idle_pct = 10;
    out_stall_pct = 30;
    for (int i = 0; i < 3; i++) begin
      send_req(REQ_SAMPLE, idx_t'(i), idx_t'($urandom), rand_sample(), rand_sample());
      send_req(REQ_READ, idx_t'(i), 4'd0, '0, '0);
      wait_results_drained();
    end
  endtask

  task automatic run_random(int n_items, int idle_pct, int stall_pct);
    int sent;
    int n_elem;
    int pick;
    idx_t r;
    idx_t c;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 80) begin
        // well-formed step with reads sprinkled in
        n_elem = ($urandom_range(3) == 0) ? NUM_ELEM : $urandom_range(1, NUM_ELEM);
        for (int x = 0; x < n_elem; x++) begin
          send_req(REQ_SAMPLE, idx_t'(x), idx_t'($urandom), rand_sample(), rand_sample());
          sent++;
          if ($urandom_range(99) < 30) begin
            r = idx_t'($urandom);
            c = ($urandom_range(9) < 8) ? idx_t'($urandom_range(int'(r))) : idx_t'($urandom);
            send_req(REQ_READ, r, c, rand_sample(), rand_sample());
            sent++;
          end
        end
      end else begin
        pick = $urandom_range(9);
        r = idx_t'($urandom);
        c = idx_t'($urandom);
        if (pick < 5) begin
          // never let a sample touch a stored slot that was never written
          if ((~step_written & ((16'h1 << r) - 16'h1)) != '0) r = '0;
          send_req(REQ_SAMPLE, r, c, rand_sample(), rand_sample());
          sent++;
        end else if (pick < 8) begin
          send_req(REQ_READ, r, c, rand_sample(), rand_sample());
          sent++;
        end else if (pick == 8) begin
          send_req(REQ_UNUSED, r, c, rand_sample(), rand_sample());
        end else begin
          send_req(REQ_CLEAR, r, c, rand_sample(), rand_sample());
          sent++;
        end
      end
    end
    wait_results_drained();
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int held;
    held = 0;
    hold_done = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (held > 0) begin
        out_if.ready <= 1'b0;
        held--;
      end else if (hold_done != hold_req) begin
        hold_done++;
        held = HOLD_LEN - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= out_stall_pct);
      end
    end
  end

  // compare each result word with the oldest pending read
  always @(posedge clk) begin
    entry_read_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected result word re=%0d im=%0d entry_valid=%0b", $time,
                 out_if.acc_re, out_if.acc_im, out_if.entry_valid);
        mismatch_count++;
      end else begin
        want = pending_reads.pop_front();
        if (out_if.acc_re !== want.re) begin
          $display("%0t: acc_re expected %0d actual %0d", $time, want.re, out_if.acc_re);
          mismatch_count++;
        end
        if (out_if.acc_im !== want.im) begin
          $display("%0t: acc_im expected %0d actual %0d", $time, want.im, out_if.acc_im);
          mismatch_count++;
        end
        if (out_if.entry_valid !== want.valid) begin
          $display("%0t: entry_valid expected %0b actual %0b", $time, want.valid,
                   out_if.entry_valid);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    mismatch_count = 0;
    in_idle_pct = 0;
    out_stall_pct = 0;
    hold_req = 0;
    idle_cycles = 0;
    step_written = '0;
    for (int i = 0; i < NUM_ELEM; i++) begin
      step_re[i] = '0;
      step_im[i] = '0;
    end
    for (int i = 0; i < TRI_ENTRIES; i++) begin
      tri_re[i] = '0;
      tri_im[i] = '0;
    end
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.req_type  <= REQ_SAMPLE;
    in_if.row       <= '0;
    in_if.column    <= '0;
    in_if.sample_re <= '0;
    in_if.sample_im <= '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_large_products();
    test_backpressure();
    test_drain_pause();
    run_random(75, 0, 0);
    run_random(75, 71, 0);
    run_random(75, 0, 71);
    run_random(75, 26, 26);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_reads.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
